/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros: shared assertion macros for the keypad entry block
// concurrent checks on clk_i, held off while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication or plain property, checked at every clock edge out of reset
`define MKDE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// property that must hold whenever a result word is on offer
`define MKDE_ASSERT_OUT(label, prop, msg) \
  `MKDE_ASSERT(label, out_valid_o |-> (prop), msg)

`endif

/* src/mkde_pkg.sv */
// ----------------------------------------------------------------------------
// mkde_pkg: types and constants for the keypad digit entry block
// word layouts, key codes and the 3x4 key map
// ----------------------------------------------------------------------------
`default_nettype none

package mkde_pkg;

  // default number of digit positions in the entry buffer
  localparam int unsigned BUFFER_DEPTH_DEF = 16;

  // keypad geometry
  localparam logic [1:0] LAST_ROW = 2'd3;
  localparam logic [1:0] LAST_COL = 2'd2;

  // value written to an erased position
  localparam logic [3:0] ERASE_CODE = 4'd10;

  // key codes: digits use their own value
  localparam logic [4:0] KEY_DELETE = 5'd20;
  localparam logic [4:0] KEY_ENTER  = 5'd21;

  // input word
  typedef struct packed {
    logic [3:0] row_levels;
    logic       clear_count;
  } in_word_t;

  // result word
  typedef struct packed {
    logic [2:0] column_drive;
    logic       write_valid;
    logic [3:0] write_index;
    logic [3:0] write_value;
    logic [4:0] digit_total;
    logic       enter_event;
    logic       overflow_flag;
  } out_word_t;

  // scan position and release wait
  typedef struct packed {
    logic [1:0] column;
    logic [1:0] row;
    logic       awaiting;
  } scan_state_t;

  // key map: column A is 1 4 7 delete, B is 2 5 8 0, C is 3 6 9 enter
  function automatic logic [4:0] key_lookup(input logic [1:0] col, input logic [1:0] row);
    logic [4:0] code;
    code = 5'd0;
    case ({col, row})
      4'b00_00: code = 5'd1;
      4'b00_01: code = 5'd4;
      4'b00_10: code = 5'd7;
      4'b00_11: code = KEY_DELETE;
      4'b01_00: code = 5'd2;
      4'b01_01: code = 5'd5;
      4'b01_10: code = 5'd8;
      4'b01_11: code = 5'd0;
      4'b10_00: code = 5'd3;
      4'b10_01: code = 5'd6;
      4'b10_10: code = 5'd9;
      4'b10_11: code = KEY_ENTER;
      default:  code = 5'd0;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

/* src/matrix_keypad_digit_entry.sv */
// ----------------------------------------------------------------------------
// matrix_keypad_digit_entry: 3x4 keypad scanner with digit entry
// one scan tick per word, emits column drive and buffer write per tick
// ----------------------------------------------------------------------------
//
//   channel  dir  handshake                  word
//   in       in   in_valid_i / in_stall_o    in_word_i  (row levels, clear)
//   out      out  out_valid_o / out_stall_i  out_word_o (drive, write, flags)
//
// one word per clock while out_stall_i is low; each word passes from accept to
// result via the input register, then the tick logic into the result register
// the scan state and entry count update as a word moves into the result
// register, so back-to-back ticks see each other's state at once
// reset clears the scan position, release wait, count and both valid bits
// in_stall_o rises only when the input register holds a word and a result
// waits on a stalled output
//
`default_nettype none

module matrix_keypad_digit_entry #(
  parameter int unsigned BUFFER_DEPTH = mkde_pkg::BUFFER_DEPTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  mkde_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output mkde_pkg::out_word_t out_word_o
);

  localparam int unsigned CountW = $clog2(BUFFER_DEPTH + 1);

  logic                  in_valid_q;
  mkde_pkg::in_word_t    in_word_q;
  logic                  out_valid_q;
  mkde_pkg::out_word_t   out_word_q;
  mkde_pkg::out_word_t   out_word_d;
  mkde_pkg::scan_state_t state_q;
  mkde_pkg::scan_state_t state_d;
  logic [CountW-1:0]     count_q;
  logic [CountW-1:0]     count_d;
  logic                  advance;
  logic                  in_take;

  // handshake control
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && out_valid_q && out_stall_i;
  assign in_take    = in_valid_i && !in_stall_o;

  // tick logic
  mkde_step #(
    .BUFFER_DEPTH(BUFFER_DEPTH),
    .CountW      (CountW)
  ) u_step (
    .in_word_i (in_word_q),
    .state_i   (state_q),
    .count_i   (count_q),
    .state_o   (state_d),
    .count_o   (count_d),
    .out_word_o(out_word_d)
  );

  // control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
      count_q     <= '0;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
        count_q     <= count_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_word_q <= in_word_i;
    end
    if (advance) begin
      out_word_q <= out_word_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // checks
  `include "assert_macros.svh"

  `MKDE_ASSERT_OUT(a_drive_one_low, $countones(out_word_o.column_drive) == 2, "column drive not one-low")
  `MKDE_ASSERT_OUT(a_single_action, !(out_word_o.write_valid && (out_word_o.enter_event || out_word_o.overflow_flag)), "write with enter or overflow")
  `MKDE_ASSERT(a_stall_holds_word, in_stall_o |=> $stable(in_word_q), "stalled input word changed")
  `MKDE_ASSERT(a_count_in_range, count_q <= CountW'(BUFFER_DEPTH), "entry count beyond depth")

endmodule

`default_nettype wire

/* src/mkde_step.sv */
// ----------------------------------------------------------------------------
// mkde_step: one scan tick of the keypad
// next scan position, entry count and result word from the current tick
// ----------------------------------------------------------------------------
`default_nettype none

module mkde_step #(
  parameter int unsigned BUFFER_DEPTH = mkde_pkg::BUFFER_DEPTH_DEF,
  parameter int unsigned CountW       = $clog2(BUFFER_DEPTH + 1)
) (
  input  mkde_pkg::in_word_t    in_word_i,
  input  mkde_pkg::scan_state_t state_i,
  input  logic [CountW-1:0]     count_i,
  output mkde_pkg::scan_state_t state_o,
  output logic [CountW-1:0]     count_o,
  output mkde_pkg::out_word_t   out_word_o
);

  localparam logic [CountW-1:0] DepthC = CountW'(BUFFER_DEPTH);

  logic [1:0]        col;
  logic              pressed;
  logic              released;
  logic              advance;
  logic [4:0]        key;
  logic [CountW-1:0] cnt_base;
  logic [CountW-1:0] cnt_next;
  logic [CountW-1:0] widx;
  logic [CountW+4:0] cnt_ext;
  logic [CountW+4:0] widx_ext;
  logic [1:0]        next_col;
  logic [1:0]        next_row;
  logic              wvalid;
  logic [3:0]        wval;
  logic              enter;
  logic              ovf;

  // sample the key under the scan position
  always_comb begin
    col      = (state_i.column > mkde_pkg::LAST_COL) ? 2'd0 : state_i.column;
    pressed  = ~in_word_i.row_levels[state_i.row];
    released = state_i.awaiting && !pressed;
    advance  = !pressed;
    key      = mkde_pkg::key_lookup(col, state_i.row);
    cnt_base = in_word_i.clear_count ? '0 : count_i;
  end

  // key action on release
  always_comb begin
    cnt_next = cnt_base;
    widx     = '0;
    wvalid   = 1'b0;
    wval     = 4'd0;
    enter    = 1'b0;
    ovf      = 1'b0;
    if (released) begin
      if (key == mkde_pkg::KEY_ENTER) begin
        enter = 1'b1;
      end else if (key == mkde_pkg::KEY_DELETE) begin
        if (cnt_base != '0) begin
          cnt_next = cnt_base - CountW'(1);
          widx     = cnt_base - CountW'(1);
          wvalid   = 1'b1;
          wval     = mkde_pkg::ERASE_CODE;
        end
      end else if (cnt_base < DepthC) begin
        cnt_next = cnt_base + CountW'(1);
        widx     = cnt_base;
        wvalid   = 1'b1;
        wval     = key[3:0];
      end else begin
        ovf = 1'b1;
      end
    end
  end

  // scan stepping: rows first, then columns, wrapping after column C
  always_comb begin
    next_col = col;
    next_row = state_i.row;
    if (advance) begin
      next_row = state_i.row + 2'd1;
      if (state_i.row == mkde_pkg::LAST_ROW) begin
        next_col = (col == mkde_pkg::LAST_COL) ? 2'd0 : col + 2'd1;
      end
    end
  end

  // next state: the release wait lasts as long as the key stays down
  always_comb begin
    state_o.column   = next_col;
    state_o.row      = next_row;
    state_o.awaiting = pressed;
    count_o          = cnt_next;
  end

  // result word, count and index cut or widened to their field widths
  always_comb begin
    cnt_ext                  = {5'd0, cnt_next};
    widx_ext                 = {5'd0, widx};
    out_word_o.column_drive  = ~(3'b001 << next_col);
    out_word_o.write_valid   = wvalid;
    out_word_o.write_index   = widx_ext[3:0];
    out_word_o.write_value   = wval;
    out_word_o.digit_total   = cnt_ext[4:0];
    out_word_o.enter_event   = enter;
    out_word_o.overflow_flag = ovf;
  end

endmodule

`default_nettype wire
